// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// Used by the cell, the scan unit and the top level; depends on nothing.
package swm_pkg;

  // Width of one sample and of the window size register.
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned SIZE_W  = 7;

  // Window size after reset.
  localparam logic [SIZE_W-1:0] WINDOW_RESET = 7'd3;

  typedef logic [VALUE_W-1:0] value_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    SWM_IDLE,
    SWM_SCAN,
    SWM_HOLD
  } swm_state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // Status from the scan unit back to the sequencer.
  typedef struct packed {
    logic last;
  } scan_stat_t;

endpackage

// ===== rtl/sliding_window_maximum.sv =====
// Top level of the sliding window maximum block: ring of sample cells,
// scan unit, sequencer, output register. Depends on swm_pkg, swm_cell, swm_scan.
//
// Samples of a row enter a ring of MAX_WINDOW cells, newest first. An item
// that completes no window only enters the ring. For an item that yields a
// result, the ring is rotated once all the way round past a single
// comparator at its tail, one cell per cycle, and the result is then moved
// into the output register once that register is free. The next item is
// taken while a finished result still waits at the output.
module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [swm_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  swm_pkg::value_t        sample_value_i,
  input  logic                   row_start_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output swm_pkg::value_t        window_max_o
);
  import swm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);

  logic [SIZE_W-1:0] window_size_q;
  logic [CNT_W-1:0]  fill_count_q, fill_count_d;
  logic [CNT_W-1:0]  win_len;
  logic [CMP_W-1:0]  size_ext;
  swm_state_e        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  value_t            window_max_q;
  logic              in_accept, out_take, out_free, load_out, has_result;
  logic              ring_en;
  value_t            ring_head;
  value_t            chain [MAX_WINDOW];
  value_t            best;
  scan_ctrl_t        scan_ctrl;
  scan_stat_t        scan_stat;

  // Configuration register: always ready; the user writes it only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_size_q <= cfg_data_i;
    end
  end

  // Effective window length: zero counts as one, large sizes saturate.
  assign size_ext = CMP_W'(window_size_q);
  always_comb begin
    if (size_ext == '0) begin
      win_len = CNT_W'(1);
    end else if (size_ext > MAX_CMP) begin
      win_len = MAX_CNT;
    end else begin
      win_len = CNT_W'(size_ext);
    end
  end

  // Handshakes.
  assign in_stall_o = (state_q != SWM_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Row fill count, restarted by row_start and saturating at the ring depth.
  always_comb begin
    fill_count_d = fill_count_q;
    if (in_accept) begin
      if (row_start_i) begin
        fill_count_d = CNT_W'(1);
      end else if (fill_count_q < MAX_CNT) begin
        fill_count_d = fill_count_q + 1'b1;
      end
    end
  end

  assign has_result = (fill_count_d >= win_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count_q <= '0;
    end else begin
      fill_count_q <= fill_count_d;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SWM_IDLE: begin
        if (in_accept && has_result) begin
          state_d = SWM_SCAN;
        end
      end
      SWM_SCAN: begin
        if (scan_stat.last) begin
          state_d = SWM_HOLD;
        end
      end
      SWM_HOLD: begin
        if (out_free) begin
          state_d = SWM_IDLE;
        end
      end
      default: state_d = SWM_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    scan_ctrl = '0;
    load_out  = 1'b0;
    unique case (state_q)
      SWM_IDLE: scan_ctrl.clear = in_accept && has_result;
      SWM_SCAN: scan_ctrl.step  = 1'b1;
      SWM_HOLD: load_out        = out_free;
      default: begin
        scan_ctrl = '0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SWM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Ring of cells: a new word shifts in at the head, a scan rotates the
  // tail word back to the head so the ring is restored after a full pass.
  assign ring_en   = in_accept || scan_ctrl.step;
  assign ring_head = in_accept ? sample_value_i : chain[MAX_WINDOW-1];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell u_cell (
        .clk_i (clk_i),
        .en_i  (ring_en),
        .d_i   (ring_head),
        .q_o   (chain[k])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk_i (clk_i),
        .en_i  (ring_en),
        .d_i   (chain[k-1]),
        .q_o   (chain[k])
      );
    end
  end

  // Comparator at the tail of the ring.
  swm_scan #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .tap_i     (chain[MAX_WINDOW-1]),
    .win_len_i (win_len),
    .best_o    (best),
    .stat_o    (scan_stat)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      window_max_q <= best;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

  // A scan only runs when the row holds a full window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWM_SCAN) |-> (fill_count_q >= win_len))
    else $error("scan running without a full window");

  // The hold state is reached only from the final step of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWM_SCAN) && !scan_stat.last |=> (state_q == SWM_SCAN))
    else $error("scan left before the ring was restored");

  // A new result appears only out of the hold state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == SWM_HOLD))
    else $error("result loaded outside the hold state");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output word overwritten");

endmodule

// ===== rtl/swm_cell.sv =====
// One storage cell of the sample ring: holds one word and takes its
// neighbor's word whenever the ring moves. Depends on swm_pkg.
module swm_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  swm_pkg::value_t d_i,
  output swm_pkg::value_t q_o
);
  import swm_pkg::*;

  value_t value_q;
  value_t value_d;

  // The cell loads its neighbor's word when the ring shifts or rotates.
  always_comb begin
    value_d = en_i ? d_i : value_q;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign q_o = value_q;

endmodule

// ===== rtl/swm_scan.sv =====
// Running maximum over the words that pass the tail of the ring, with a
// position counter that keeps only the positions inside the window.
// Depends on swm_pkg.
module swm_scan #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swm_pkg::scan_ctrl_t                 ctrl_i,
  input  swm_pkg::value_t                     tap_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     win_len_i,
  output swm_pkg::value_t                     best_o,
  output swm_pkg::scan_stat_t                 stat_o
);
  import swm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_WINDOW - 1);

  logic [IDX_W-1:0] pos_q, pos_d;
  value_t           best_q, best_d;
  logic             in_window;

  // The tail word belongs to the window when its age is below the length.
  assign in_window = (CNT_W'(pos_q) < win_len_i);

  // Clear starts a pass at the oldest position; each step folds in one word.
  always_comb begin
    pos_d  = pos_q;
    best_d = best_q;
    if (ctrl_i.clear) begin
      pos_d  = LAST_POS;
      best_d = '0;
    end else if (ctrl_i.step) begin
      if (in_window && (tap_i > best_q)) begin
        best_d = tap_i;
      end
      if (pos_q != '0) begin
        pos_d = pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign best_o      = best_q;
  assign stat_o.last = (pos_q == '0);

endmodule

// ===== test/testbench.sv =====
// Testbench for sliding_window_maximum: directed and random rows against a predictor.
// Depends on swm_pkg and the sliding_window_maximum RTL; it reads no files.
module testbench;
  import swm_pkg::*;

  localparam int unsigned MAX_WINDOW  = 64;
  localparam int unsigned ITEM_GOAL   = 1100;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned SETTLE      = MAX_WINDOW + 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Predicts the window maximum for every accepted word and checks results in order.
  class max_predictor;
    value_t            history[MAX_WINDOW];
    int unsigned       row_fill;
    logic [SIZE_W-1:0] size_reg;
    value_t            expected_max[$];
    int unsigned       errors;

    function new();
      row_fill = 0;
      size_reg = WINDOW_RESET;
      errors   = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void set_window(logic [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    // Zero acts as one and anything past the ring size is clipped.
    function int unsigned span();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_WINDOW) return MAX_WINDOW;
      return size_reg;
    endfunction

    function void take_sample(value_t v, logic first);
      int unsigned w;
      value_t      best;
      w = span();
      if (first) row_fill = 0;
      for (int i = MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = v;
      if (row_fill < MAX_WINDOW) row_fill++;
      if (row_fill >= w) begin
        best = '0;
        for (int i = 0; i < w; i++) if (history[i] > best) best = history[i];
        expected_max.push_back(best);
      end
    endfunction

    function void compare_max(value_t got);
      value_t want;
      if (expected_max.size() == 0) begin
        $display("%0t: unexpected window_max, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_max.pop_front();
        if (got !== want) begin
          $display("%0t: window_max mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_max.size();
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  value_t            sample_value = '0;
  logic              row_start    = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  value_t            window_max;

  max_predictor      pred;
  bit                idling_on    = 1'b1;
  bit                hold_request = 1'b0;
  int unsigned       items_sent   = 0;
  int unsigned       cycles       = 0;

  sliding_window_maximum #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_value_i(sample_value),
    .row_start_i   (row_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .window_max_o  (window_max)
  );

  // Clock with a period of ten units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Every word taken from the output is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pred.compare_max(window_max);
  end

  // Offers one word, maybe after a random gap, and returns once it is accepted.
  task automatic send_sample(value_t v, logic first);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    row_start    <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.take_sample(v, first);
    items_sent++;
  endtask

  // Stops sending until every predicted result has come out, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pred.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window_size(logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred.set_window(v);
  endtask

  // Full random values half the time, with the extremes and small values mixed in.
  function automatic value_t rand_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return value_t'($urandom_range(0, 15));
      default: return value_t'($urandom);
    endcase
  endfunction

  // Rows mostly longer than the window, some short ones, some stray row starts,
  // and now and then a row that lacks its opening flag.
  task automatic run_rows(int unsigned count);
    int unsigned left;
    int unsigned row_len;
    int unsigned w;
    logic        first;
    left = count;
    while (left > 0) begin
      w = pred.span();
      case ($urandom_range(0, 9))
        0:       row_len = $urandom_range(1, w);
        1:       row_len = $urandom_range(1, 4);
        default: row_len = w + $urandom_range(0, 2 * w + 10);
      endcase
      for (int k = 0; k < row_len && left > 0; k++) begin
        if (k == 0) first = ($urandom_range(0, 7) != 0);
        else first = ($urandom_range(0, 31) == 0);
        send_sample(rand_sample(), first);
        left--;
      end
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_window(int unsigned phase);
    case (phase)
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd2;
      3: return 7'd127;
      4: return 7'd0;
      5: return 7'd65;
      default: begin
        case ($urandom_range(0, 9))
          0, 1:    return SIZE_W'($urandom_range(0, 127));
          2, 3:    return SIZE_W'($urandom_range(9, 64));
          default: return SIZE_W'($urandom_range(1, 8));
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned       phase;
    int unsigned       count;
    logic [SIZE_W-1:0] wsize;

    pred = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window of three, values before any row start, field extremes.
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h000001, 1'b0);
    // A row shorter than the window, then a full row.
    send_sample(24'h000005, 1'b1);
    send_sample(24'h000006, 1'b0);
    send_sample(24'h000007, 1'b1);
    send_sample(24'h000008, 1'b0);
    send_sample(24'h000009, 1'b0);
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h555555, 1'b0);
    drain_results();

    // A size of zero acts as one.
    write_window_size(7'd0);
    send_sample(24'h123456, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h000001, 1'b0);
    drain_results();

    // The row goes on across size changes: the largest size gives nothing yet,
    // then a size of one resumes results on the values already held.
    write_window_size(7'd127);
    send_sample(24'hFEDCBA, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    drain_results();
    write_window_size(7'd1);
    send_sample(24'h000010, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    drain_results();

    // Random phases, each with its own window size.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent + QUIET_TAIL >= ITEM_GOAL) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      wsize = pick_window(phase);
      write_window_size(wsize);
      count = $urandom_range(40, 90) + 2 * pred.span();
      if (phase == 0) begin
        // Long receiver hold-off while words keep coming, so the block backs up.
        idling_on    = 1'b0;
        hold_request = 1'b1;
        run_rows(count);
      end else if (phase == 2) begin
        // The sender pauses mid-phase until every result is out.
        run_rows(count / 2);
        drain_results();
        run_rows(count - count / 2);
      end else begin
        run_rows(count);
      end
      drain_results();
      phase++;
    end

    in_valid <= 1'b0;
    while (pred.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pred.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
